@@ src/csc_wheel_speed_distance_assert.svh @@
// assertion macros for the wheel speed and distance block
// used by the port checker; needs a clock and reset in scope
`ifndef CSC_WHEEL_SPEED_DISTANCE_ASSERT_SVH
`define CSC_WHEEL_SPEED_DISTANCE_ASSERT_SVH

// same-cycle implication
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/csc_pkg.sv @@
// shared types and constants for the wheel speed and distance block
// no dependencies
package csc_pkg;

   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_BASELINE     = 4'd1;
   localparam logic [3:0] ST_REBASELINE   = 4'd2;
   localparam logic [3:0] ST_NO_UPDATE    = 4'd3;
   localparam logic [3:0] ST_NO_WHEEL     = 4'd4;
   localparam logic [3:0] ST_BAD_ARGUMENT = 4'd5;
   localparam logic [3:0] ST_BAD_FLAGS    = 4'd6;
   localparam logic [3:0] ST_BAD_LENGTH   = 4'd7;
   localparam logic [3:0] ST_OUT_OF_RANGE = 4'd8;

   localparam logic [7:0]  RESERVED_MASK = 8'hFC;
   localparam logic [3:0]  COUNT_LIMIT   = 4'd12;
   localparam logic [15:0] CIRC_RESET    = 16'd2105;
   localparam logic [9:0]  MM_PER_M      = 10'd1000;
   localparam logic [6:0]  DIV_STEPS     = 7'd65;

   localparam logic [1:0] REG_CIRC = 2'd0;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_MUL, S_PREP, S_DIV, S_FIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic check;
      logic mul;
      logic prep;
      logic div_step;
      logic load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic terminal;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

@@ src/csc_ctrl.sv @@
// controller for the wheel speed and distance block
// depends on csc_pkg
module csc_ctrl import csc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_tlast,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid && req_tlast) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.terminal ? S_FIN : S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ src/csc_dp.sv @@
// datapath: byte capture, checks, multiply, serial divide, output word
// depends on csc_pkg
module csc_dp import csc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   payload_byte,
   input  logic         last_byte,
   input  logic [15:0]  circ,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [119:0] rsp_tdata
);

   logic [3:0]  count_ff, len_ff;
   logic [7:0]  flag_ff;
   logic [31:0] rx_revs_ff, prev_revs_ff, drevs_ff;
   logic [15:0] rx_time_ff, prev_time_ff, dticks_ff;
   logic        base_set_ff, acc_ff, ovf_ff, qhi_ff, out_valid_ff;
   logic [63:0] dist_ff, sum_ff;
   logic [3:0]  st_ff;
   logic [47:0] ddist_ff;
   logic [25:0] den_ff;
   logic [64:0] divd_ff;
   logic [25:0] rem_ff;
   logic [15:0] q_ff;
   logic [6:0]  step_ff;
   logic [119:0] out_ff;

   logic [3:0]  count_next, expected, chk_st;
   logic        chk_acc, chk_term;
   logic [31:0] drevs;
   logic [15:0] dticks;
   logic [64:0] sum_wide, num_rnd;
   logic [26:0] trial;
   logic        fits, fin_ok, commit_acc;
   logic [3:0]  fin_st;

   assign count_next = (count_ff < COUNT_LIMIT) ? count_ff + 4'd1 : COUNT_LIMIT;

   // byte capture
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         flag_ff    <= '0;
         rx_revs_ff <= '0;
         rx_time_ff <= '0;
      end else if (cmd.capture) begin
         count_ff <= last_byte ? 4'd0 : count_next;
         case (count_ff)
            4'd0: flag_ff <= payload_byte;
            4'd1: rx_revs_ff[7:0]   <= payload_byte;
            4'd2: rx_revs_ff[15:8]  <= payload_byte;
            4'd3: rx_revs_ff[23:16] <= payload_byte;
            4'd4: rx_revs_ff[31:24] <= payload_byte;
            4'd5: rx_time_ff[7:0]   <= payload_byte;
            4'd6: rx_time_ff[15:8]  <= payload_byte;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && last_byte) len_ff <= count_next;
   end

   // checks in priority order
   assign drevs    = rx_revs_ff - prev_revs_ff;
   assign dticks   = rx_time_ff - prev_time_ff;
   assign expected = 4'd1 + (flag_ff[0] ? 4'd6 : 4'd0) + (flag_ff[1] ? 4'd4 : 4'd0);

   always_comb begin
      chk_acc  = 1'b0;
      chk_term = 1'b1;
      if ((flag_ff & RESERVED_MASK) != 8'd0) chk_st = ST_BAD_FLAGS;
      else if (len_ff != expected)           chk_st = ST_BAD_LENGTH;
      else if (circ == 16'd0)                chk_st = ST_BAD_ARGUMENT;
      else if (!flag_ff[0])                  chk_st = ST_NO_WHEEL;
      else if (!base_set_ff) begin
         chk_st  = ST_BASELINE;
         chk_acc = 1'b1;
      end else if (rx_revs_ff < prev_revs_ff) begin
         chk_st  = ST_REBASELINE;
         chk_acc = 1'b1;
      end else if (dticks == 16'd0)          chk_st = ST_NO_UPDATE;
      else if (drevs == 32'd0) begin
         chk_st  = ST_NO_UPDATE;
         chk_acc = 1'b1;
      end else begin
         chk_st   = ST_OK;
         chk_acc  = 1'b1;
         chk_term = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         st_ff     <= chk_st;
         acc_ff    <= chk_acc;
         drevs_ff  <= drevs;
         dticks_ff <= dticks;
      end
   end

   // multiply, then distance sum and rounded dividend
   // num = ddist * 36864 = (ddist << 15) + (ddist << 12)
   assign sum_wide = {1'b0, dist_ff} + {17'd0, ddist_ff};
   assign num_rnd  = {2'b0, ddist_ff, 15'd0} + {5'b0, ddist_ff, 12'd0}
                   + {40'd0, den_ff[25:1]};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         ddist_ff <= {16'd0, drevs_ff} * {32'd0, circ};
         den_ff   <= {10'd0, dticks_ff} * {16'd0, MM_PER_M};
      end
      if (cmd.prep) begin
         ovf_ff  <= sum_wide[64];
         sum_ff  <= sum_wide[63:0];
      end
   end

   // restoring divide, one quotient bit a cycle
   assign trial = {rem_ff, divd_ff[64]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.prep) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff  <= '0;
         q_ff    <= '0;
         qhi_ff  <= 1'b0;
         divd_ff <= num_rnd;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? 26'(trial - {1'b0, den_ff}) : trial[25:0];
         divd_ff <= {divd_ff[63:0], 1'b0};
         q_ff    <= {q_ff[14:0], fits};
         qhi_ff  <= qhi_ff | q_ff[15];
      end
   end

   assign stat.div_last = (step_ff == DIV_STEPS - 7'd1);
   assign stat.terminal = chk_term;
   assign stat.out_free = !out_valid_ff || rsp_tready;

   // final status and state commit
   assign fin_ok     = (st_ff == ST_OK) && !ovf_ff && !qhi_ff;
   assign fin_st     = (st_ff == ST_OK) ? (fin_ok ? ST_OK : ST_OUT_OF_RANGE) : st_ff;
   assign commit_acc = acc_ff && ((st_ff != ST_OK) || fin_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_set_ff  <= 1'b0;
         prev_revs_ff <= '0;
         prev_time_ff <= '0;
         dist_ff      <= '0;
      end else if (cmd.load) begin
         if (st_ff == ST_BASELINE) base_set_ff <= 1'b1;
         if (commit_acc) begin
            prev_revs_ff <= rx_revs_ff;
            prev_time_ff <= rx_time_ff;
         end
         if (fin_ok) dist_ff <= sum_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_ff <= {3'd0,
                    fin_ok ? sum_ff : dist_ff,
                    fin_ok ? drevs_ff : 32'd0,
                    fin_ok ? q_ff : 16'd0,
                    fin_ok,
                    fin_st};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

@@ src/csc_wheel_speed_distance.sv @@
// Wheel speed and distance decoder, top level.
// Takes one payload byte a cycle while idle. After the last byte, a check state
// leads to the finish state for a check-only status, or via multiply, prep and a
// 65-step restoring divider (one quotient bit a cycle). One payload at a time.
// Reset (synchronous, active high) clears all wheel state and distance,
// and sets the circumference register to 2105 mm.
module csc_wheel_speed_distance import csc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // payload_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[3:0], speed_valid[4], speed_kmh_x10[20:5], revolutions_delta[52:21],
   // total_distance_mm[116:53], zero fill
   output logic [119:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [15:0] circ_ff;
   cmd_type     cmd;
   stat_type    stat;

   // circumference register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= CIRC_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_CIRC) begin
         circ_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = (csr_paddr == REG_CIRC) ? {16'd0, circ_ff} : 32'd0;

   csc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   csc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .payload_byte (req_tdata),
      .last_byte    (req_tlast),
      .circ         (circ_ff),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

@@ src/csc_chk.sv @@
// port checker for the wheel speed and distance block, bound to the top
// depends on csc_pkg and csc_wheel_speed_distance_assert.svh
`include "csc_wheel_speed_distance_assert.svh"
module csc_chk import csc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata
);

   // stalled result word holds
   `CSC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   // speed valid only with ok status
   `CSC_ASSERT_NOW(a_valid_ok, rsp_tvalid && rsp_tdata[4], rsp_tdata[3:0] == ST_OK, "speed valid without ok status")
   // ok status always carries a speed
   `CSC_ASSERT_NOW(a_ok_valid, rsp_tvalid && rsp_tdata[3:0] == ST_OK, rsp_tdata[4], "ok status without speed")
   // no speed means zero speed and delta
   `CSC_ASSERT_NOW(a_zero_fields, rsp_tvalid && !rsp_tdata[4], rsp_tdata[52:5] == 48'd0, "speed fields set without valid")

endmodule

bind csc_wheel_speed_distance csc_chk u_chk (.*);

@@ verif/tb.sv @@
// testbench for the wheel speed and distance decoder
// depends on csc_pkg and csc_wheel_speed_distance; self-checking, no files read
module tb;
   import csc_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // payload_byte
   logic         req_tlast;    // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready;
   // status[3:0], speed_valid[4], speed_kmh_x10[20:5], revolutions_delta[52:21],
   // total_distance_mm[116:53], zero fill
   logic [119:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [1:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_word_t;

   typedef struct packed {
      logic [3:0]  status;
      logic        valid;
      logic [15:0] kmh;
      logic [31:0] revs;
      logic [63:0] total;
   } status_word_t;

   csc_wheel_speed_distance u_top (.*);

   // clock
   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // stimulus and expectation stores
   byte_word_t   byte_q[$];
   status_word_t status_q[$];
   int           n_queued;
   int           n_accepted;
   int           n_errors;
   bit           quiet;
   bit           req_fired;
   bit           rsp_fired;
   int           req_gap;
   int           rsp_stall;

   // decoder mirror
   logic [15:0]  m_circ;
   logic [3:0]   m_count;
   logic [7:0]   m_flags;
   logic [31:0]  m_rx_revs;
   logic [15:0]  m_rx_time;
   logic         m_based;
   logic [31:0]  m_prev_revs;
   logic [15:0]  m_prev_time;
   logic [63:0]  m_dist;

   // stimulus-side wheel position
   logic [31:0]  g_revs;
   logic [15:0]  g_time;

   task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
      n_errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   function automatic status_word_t wheel_update(input logic [3:0] len);
      status_word_t r;
      logic [3:0]   need;
      logic [31:0]  drevs;
      logic [15:0]  dticks;
      logic [127:0] ddist, num, den, kmh;
      r = '0;
      need = 4'd1 + (m_flags[0] ? 4'd6 : 4'd0) + (m_flags[1] ? 4'd4 : 4'd0);
      drevs = m_rx_revs - m_prev_revs;
      dticks = m_rx_time - m_prev_time;
      if ((m_flags & RESERVED_MASK) != 0) r.status = ST_BAD_FLAGS;
      else if (len != need) r.status = ST_BAD_LENGTH;
      else if (m_circ == 0) r.status = ST_BAD_ARGUMENT;
      else if (!m_flags[0]) r.status = ST_NO_WHEEL;
      else if (!m_based) begin
         m_based = 1'b1;
         m_prev_revs = m_rx_revs;
         m_prev_time = m_rx_time;
         r.status = ST_BASELINE;
      end else if (m_rx_revs < m_prev_revs) begin
         m_prev_revs = m_rx_revs;
         m_prev_time = m_rx_time;
         r.status = ST_REBASELINE;
      end else if (dticks == 0) r.status = ST_NO_UPDATE;
      else if (drevs == 0) begin
         m_prev_revs = m_rx_revs;
         m_prev_time = m_rx_time;
         r.status = ST_NO_UPDATE;
      end else begin
         ddist = drevs * m_circ;
         num = ddist * 128'd36864;
         den = dticks * 128'd1000;
         kmh = (num + den / 2) / den;
         if ({64'd0, m_dist} + ddist > 128'hFFFF_FFFF_FFFF_FFFF || kmh > 128'hFFFF)
            r.status = ST_OUT_OF_RANGE;
         else begin
            m_prev_revs = m_rx_revs;
            m_prev_time = m_rx_time;
            m_dist = m_dist + ddist[63:0];
            r.status = ST_OK;
            r.valid = 1'b1;
            r.kmh = kmh[15:0];
            r.revs = drevs;
         end
      end
      r.total = m_dist;
      return r;
   endfunction

   // byte accepted: capture fields, predict a status on the last byte
   task automatic take_byte(input logic [7:0] b, input logic last);
      logic [3:0] pos;
      pos = m_count;
      case (pos)
         4'd0: m_flags = b;
         4'd1: m_rx_revs[7:0] = b;
         4'd2: m_rx_revs[15:8] = b;
         4'd3: m_rx_revs[23:16] = b;
         4'd4: m_rx_revs[31:24] = b;
         4'd5: m_rx_time[7:0] = b;
         4'd6: m_rx_time[15:8] = b;
         default: ;
      endcase
      if (m_count < COUNT_LIMIT) m_count++;
      if (last) begin
         status_q.push_back(wheel_update(m_count));
         m_count = 0;
      end
   endtask

   // driver, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && !req_fired) begin
            req_tvalid <= 1'b1;
         end else if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (byte_q.size() > 0) begin
            byte_word_t w;
            w = byte_q.pop_front();
            req_tdata <= w.data;
            req_tlast <= w.last;
            req_tvalid <= 1'b1;
            req_gap = quiet ? 0 : $urandom_range(0, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
         if (rsp_fired) rsp_stall = quiet ? 0 : $urandom_range(0, 14);
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor, outputs sampled on the rising edge
   always @(posedge clock) begin
      req_fired <= !reset && req_tvalid && req_tready;
      rsp_fired <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            n_accepted++;
            take_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            status_word_t e;
            if (status_q.size() == 0) begin
               report("unexpected word", rsp_tdata, 0);
            end else begin
               e = status_q.pop_front();
               if (rsp_tdata[3:0] != e.status) report("status", rsp_tdata[3:0], e.status);
               if (rsp_tdata[4] != e.valid) report("speed_valid", rsp_tdata[4], e.valid);
               if (rsp_tdata[20:5] != e.kmh) report("speed_kmh_x10", rsp_tdata[20:5], e.kmh);
               if (rsp_tdata[52:21] != e.revs)
                  report("revolutions_delta", rsp_tdata[52:21], e.revs);
               if (rsp_tdata[116:53] != e.total)
                  report("total_distance_mm", rsp_tdata[116:53], e.total);
            end
         end
      end
   end

   // one payload; len_force of 0 keeps the length its flags call for
   task automatic send_packet(input logic [7:0] flags, input logic [31:0] revs,
                              input logic [15:0] ticks, input int len_force);
      byte_word_t w;
      logic [7:0] body[$];
      int         len;
      body = '{flags, revs[7:0], revs[15:8], revs[23:16], revs[31:24], ticks[7:0], ticks[15:8]};
      len = 1 + (flags[0] ? 6 : 0) + (flags[1] ? 4 : 0);
      if (len_force > 0) len = len_force;
      if (!flags[0]) body = '{flags};
      for (int i = 0; i < len; i++) begin
         w.data = (i < body.size()) ? body[i] : 8'($urandom_range(0, 255));
         w.last = (i == len - 1);
         byte_q.push_back(w);
         n_queued++;
      end
   endtask

   // well-formed wheel payload moving the wheel forward
   task automatic ride(input int max_revs, input int max_ticks);
      g_revs = g_revs + $urandom_range(0, max_revs);
      g_time = g_time + 16'($urandom_range(0, max_ticks));
      send_packet(8'($urandom_range(0, 1) ? 1 : 3), g_revs, g_time, 0);
   endtask

   task automatic drain();
      while (n_accepted != n_queued || status_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_circ(input logic [15:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= REG_CIRC; csr_pwdata <= {16'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      m_circ = v;
      @(negedge clock);
      csr_pwrite <= 1'b0; csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] != v) report("circumference readback", csr_prdata, v);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   // random payloads, mostly well formed
   task automatic random_phase(input int packets);
      for (int p = 0; p < packets; p++) begin
         int k;
         k = $urandom_range(0, 99);
         if (k < 65) ride(12, 3000);
         else if (k < 72) ride(0, 2000);
         else if (k < 77) ride(9, 0);
         else if (k < 82) begin
            g_revs = $urandom;
            g_time = 16'($urandom);
            send_packet(8'h01, g_revs, g_time, 0);
         end else if (k < 86) ride(5000, 3);
         else if (k < 90) send_packet(8'($urandom_range(0, 255)), $urandom, 16'($urandom), 0);
         else if (k < 95) send_packet(8'($urandom_range(0, 3)), $urandom, 16'($urandom),
                                      $urandom_range(1, 14));
         else send_packet(8'($urandom_range(0, 3) & 8'h2), g_revs, g_time, 0);
      end
   endtask

   initial begin
      logic [15:0] circ_set[5];
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      n_queued = 0; n_accepted = 0; n_errors = 0; quiet = 1'b0;
      req_gap = 0; rsp_stall = 0;
      m_circ = CIRC_RESET; m_count = 0; m_flags = 0; m_rx_revs = 0; m_rx_time = 0;
      m_based = 1'b0; m_prev_revs = 0; m_prev_time = 0; m_dist = 0;
      g_revs = 0; g_time = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: baseline at reset circumference, then every status but bad argument
      send_packet(8'h01, 32'hFFFF_FF00, 16'h0000, 0);  // baseline
      send_packet(8'h03, 32'hFFFF_FFFF, 16'hFFFF, 0);  // ok, extreme bytes
      send_packet(8'h03, 32'h0000_0010, 16'h0100, 0);  // count falls: rebaseline
      send_packet(8'h01, 32'h0000_0014, 16'h0100, 0);  // zero ticks
      send_packet(8'h01, 32'h0000_0014, 16'h0200, 0);  // ok: revolutions rise against the last accepted count
      send_packet(8'h01, 32'h0000_4000, 16'h0201, 0);  // speed out of range
      send_packet(8'h01, 32'h0000_0020, 16'h0600, 0);  // ok
      send_packet(8'hFC, 32'h0, 16'h0, 0);             // reserved flags
      send_packet(8'h00, 32'h0, 16'h0, 0);             // no wheel
      send_packet(8'h02, 32'h0, 16'h0, 0);             // crank only
      send_packet(8'h01, 32'h0, 16'h0, 5);             // short
      send_packet(8'h03, 32'h0, 16'h0, 14);            // overlong, saturating count
      drain();

      // zero circumference: bad argument
      write_circ(16'd0);
      send_packet(8'h01, 32'h30, 16'h0900, 0);
      send_packet(8'h00, 32'h0, 16'h0, 0);
      drain();

      circ_set = '{16'd65535, 16'd1, 16'd2105, 16'($urandom_range(1, 65535)), 16'd0};
      for (int ph = 0; ph < 5; ph++) begin
         write_circ(circ_set[ph]);
         quiet = (ph == 2);
         random_phase(20);
         drain();
      end
      write_circ(16'd700);
      random_phase(20);
      drain();

      if (n_errors == 0) $display("** csc_wheel_speed_distance: PASSED **");
      else $display("** csc_wheel_speed_distance: FAILED **");
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("** csc_wheel_speed_distance: FAILED **");
      $finish;
   end

endmodule
